// ===== sv/lrbc_pkg.sv =====
// Shared types, register indexes and constants for the retry backoff controller.
// No dependencies; every other file but lrbc_stream_if imports this package.
`default_nettype none

package lrbc_pkg;

    // Highest server count the round robin will use
    localparam int unsigned MAX_SERVERS = 16;
    localparam logic [4:0]  SRV_LIMIT   = (MAX_SERVERS < 16) ? 5'(MAX_SERVERS) : 5'd16;

    localparam logic [15:0] INITIAL_DELAY_RST     = 16'd100;
    localparam logic [15:0] DELAY_CAP_RST         = 16'd2000;
    localparam logic [7:0]  RETRY_LIMIT_RST       = 8'd10;
    localparam logic [19:0] CMD_TIMEOUT_RST       = 20'd30000;
    localparam logic [4:0]  SERVER_COUNT_RST      = 5'd1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_CAP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_TIMEOUT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT      = 3'd4;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_REPLY = 2'd1,
        REQ_TICK  = 2'd2
    } req_kind_t;

    typedef enum logic [2:0] {
        OUT_SEND         = 3'd0,
        OUT_SUCCESS      = 3'd1,
        OUT_SERVER_ERROR = 3'd2,
        OUT_TIMEOUT      = 3'd3,
        OUT_RETRIES      = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       rpc_ok;
        logic       reply_success;
        logic       leader_given;
        logic [3:0] leader_server;
    } lrbc_req_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [3:0]  target_server;
        logic [7:0]  attempt_number;
        logic [31:0] command_sequence;
    } lrbc_rsp_t;

    typedef struct packed {
        logic [15:0] initial_delay;
        logic [15:0] delay_cap;
        logic [7:0]  retry_limit;
        logic [19:0] cmd_timeout;
        logic [4:0]  server_count;
    } lrbc_cfg_t;

    // Registered item waiting in the input stage
    typedef struct packed {
        logic      valid;
        lrbc_req_t data;
    } lrbc_item_t;

    // Result of one processed item
    typedef struct packed {
        logic      valid;
        lrbc_rsp_t data;
    } lrbc_result_t;

endpackage

`default_nettype wire

// ===== sv/lrbc_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
// Used for both the request and the result channel; no dependencies.
`default_nettype none

interface lrbc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/leader_retry_backoff_controller_core.sv =====
// Path: an accepted item is held in the input register, and any result it gives then in the result register.
// Throughput: one item per cycle while results are taken; the input register refills while the result register drains.
// An item waits in the input register only while a previous result is not yet taken.
// Reset (rst_n low, asynchronous): both stages empty, command idle, sequence number 1,
// configuration registers back to their defaults.
`default_nettype none

module leader_retry_backoff_controller_core
    import lrbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lrbc_stream_if.sink                req,
    lrbc_stream_if.source              rsp,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    lrbc_cfg_t    cfg;
    lrbc_item_t   item;
    lrbc_result_t res;
    logic         fire;

    assign fire = item.valid && (!rsp.valid || rsp.ready);

    lrbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrbc_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (fire),
        .item    (item)
    );

    lrbc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .fire     (fire),
        .req_data (item.data),
        .res      (res)
    );

    lrbc_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .res   (res),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== sv/lrbc_cfg_regs.sv =====
// Configuration register file of the retry backoff controller.
// Depends on lrbc_pkg.
`default_nettype none

module lrbc_cfg_regs
    import lrbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output lrbc_cfg_t                  cfg
);

    lrbc_cfg_t cfg_reg;
    lrbc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INITIAL_DELAY:     cfg_next.initial_delay     = cfg_data[15:0];
                CFG_DELAY_CAP:         cfg_next.delay_cap         = cfg_data[15:0];
                CFG_RETRY_LIMIT:       cfg_next.retry_limit       = cfg_data[7:0];
                CFG_CMD_TIMEOUT:       cfg_next.cmd_timeout       = cfg_data[19:0];
                CFG_SERVER_COUNT:      cfg_next.server_count      = cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay     <= INITIAL_DELAY_RST;
            cfg_reg.delay_cap         <= DELAY_CAP_RST;
            cfg_reg.retry_limit       <= RETRY_LIMIT_RST;
            cfg_reg.cmd_timeout       <= CMD_TIMEOUT_RST;
            cfg_reg.server_count      <= SERVER_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/lrbc_in_stage.sv =====
// Input register of the retry backoff controller: holds one accepted item.
// Depends on lrbc_pkg and lrbc_stream_if.
`default_nettype none

module lrbc_in_stage
    import lrbc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lrbc_stream_if.sink  req,
    input  wire logic    advance,
    output lrbc_item_t   item
);

    logic      valid_reg;
    logic      valid_next;
    lrbc_req_t data_reg;
    logic      take;

    // Refill in the same cycle the held item moves on
    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= req.data;
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/lrbc_engine.sv =====
// Command state and single-pass next-state logic of the retry backoff controller.
// Depends on lrbc_pkg.
`default_nettype none

module lrbc_engine
    import lrbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lrbc_cfg_t  cfg,
    input  wire logic       fire,
    input  wire lrbc_req_t  req_data,
    output lrbc_result_t    res
);

    logic        busy_reg,         busy_next;
    logic        waiting_reg,      waiting_next;
    logic [7:0]  attempt_reg,      attempt_next;
    logic [15:0] wait_left_reg,    wait_left_next;
    logic [15:0] next_delay_reg,   next_delay_next;
    logic [19:0] elapsed_reg,      elapsed_next;
    logic        leader_known_reg, leader_known_next;
    logic [3:0]  leader_index_reg, leader_index_next;
    logic [3:0]  next_server_reg,  next_server_next;
    logic [31:0] seq_reg,          seq_next;

    logic [4:0]  eff_count;
    logic [3:0]  ns_eff;
    logic [4:0]  ns_inc;
    logic [3:0]  ns_adv;
    logic [8:0]  boff_k;
    logic [15:0] boff;
    logic [3:0]  tgt_cur;
    logic [7:0]  attempt_bump;
    logic [15:0] wl_dec;
    logic [3:0]  tgt_na;
    logic        do_na;

    // min(init << k, cap), shift saturating to the cap
    function automatic logic [15:0] backoff_calc(
        input logic [15:0] init,
        input logic [15:0] cap,
        input logic [8:0]  k
    );
        logic [31:0] d;
        begin
            d = {16'd0, init} << k[4:0];
            if (init == 16'd0)
                backoff_calc = 16'd0;
            else if (k >= 9'd17)
                backoff_calc = cap;
            else if (d > {16'd0, cap})
                backoff_calc = cap;
            else
                backoff_calc = d[15:0];
        end
    endfunction

    always_comb
    begin
        if (cfg.server_count == 5'd0)
            eff_count = 5'd1;
        else if (cfg.server_count > SRV_LIMIT)
            eff_count = SRV_LIMIT;
        else
            eff_count = cfg.server_count;
    end

    assign ns_eff       = ({1'b0, next_server_reg} >= eff_count) ? 4'd0 : next_server_reg;
    assign ns_inc       = {1'b0, ns_eff} + 5'd1;
    assign ns_adv       = (ns_inc >= eff_count) ? 4'd0 : ns_inc[3:0];
    assign boff_k       = (req_data.req_type == REQ_START) ? 9'd0 : {1'b0, attempt_reg} + 9'd1;
    assign boff         = backoff_calc(cfg.initial_delay, cfg.delay_cap, boff_k);
    assign tgt_cur      = leader_known_reg ? leader_index_reg : ns_eff;
    assign attempt_bump = (attempt_reg != 8'hFF) ? attempt_reg + 8'd1 : attempt_reg;
    assign wl_dec       = (wait_left_reg != 16'd0) ? wait_left_reg - 16'd1 : wait_left_reg;

    always_comb
    begin
        busy_next         = busy_reg;
        waiting_next      = waiting_reg;
        attempt_next      = attempt_reg;
        wait_left_next    = wait_left_reg;
        next_delay_next   = next_delay_reg;
        elapsed_next      = elapsed_reg;
        leader_known_next = leader_known_reg;
        leader_index_next = leader_index_reg;
        next_server_next  = next_server_reg;
        seq_next          = seq_reg;
        do_na             = 1'b0;
        tgt_na            = 4'd0;
        res               = '0;

        if (fire)
        begin
            case (req_data.req_type)
                REQ_START:
                begin
                    seq_next          = seq_reg + 32'd1;
                    busy_next         = 1'b1;
                    waiting_next      = 1'b0;
                    leader_known_next = 1'b0;
                    attempt_next      = 8'd0;
                    elapsed_next      = 20'd0;
                    wait_left_next    = 16'd0;
                    next_delay_next   = boff;
                    next_server_next  = ns_eff;
                    do_na             = 1'b1;
                end
                REQ_REPLY:
                begin
                    if (busy_reg && !waiting_reg)
                    begin
                        next_server_next = ns_eff;
                        if (req_data.rpc_ok)
                        begin
                            if (req_data.reply_success)
                            begin
                                busy_next              = 1'b0;
                                res.valid              = 1'b1;
                                res.data.outcome       = OUT_SUCCESS;
                                res.data.target_server = tgt_cur;
                                res.data.attempt_number = attempt_reg + 8'd1;
                            end
                            else if (req_data.leader_given)
                            begin
                                leader_known_next = 1'b1;
                                leader_index_next = req_data.leader_server;
                                attempt_next      = attempt_bump;
                                do_na             = 1'b1;
                            end
                            else
                            begin
                                busy_next              = 1'b0;
                                res.valid              = 1'b1;
                                res.data.outcome       = OUT_SERVER_ERROR;
                                res.data.target_server = tgt_cur;
                                res.data.attempt_number = attempt_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            // network failure: arm the backoff, maybe rotate server
                            wait_left_next  = next_delay_reg;
                            next_delay_next = boff;
                            if (!leader_known_reg)
                                next_server_next = ns_adv;
                            attempt_next = attempt_bump;
                            if (next_delay_reg == 16'd0)
                                do_na = 1'b1;
                            else
                                waiting_next = 1'b1;
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (busy_reg)
                    begin
                        if (elapsed_reg != 20'hFFFFF)
                            elapsed_next = elapsed_reg + 20'd1;
                        if (waiting_reg)
                        begin
                            wait_left_next = wl_dec;
                            if (wl_dec == 16'd0)
                            begin
                                waiting_next     = 1'b0;
                                next_server_next = ns_eff;
                                do_na            = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase

            // limit and timeout checks ahead of every attempt
            if (do_na)
            begin
                tgt_na                 = leader_known_next ? leader_index_next
                                                           : next_server_next;
                res.valid              = 1'b1;
                res.data.target_server = tgt_na;
                if (attempt_next >= cfg.retry_limit)
                begin
                    busy_next               = 1'b0;
                    waiting_next            = 1'b0;
                    res.data.outcome        = OUT_RETRIES;
                    res.data.attempt_number = attempt_next;
                end
                else if (elapsed_next > cfg.cmd_timeout)
                begin
                    busy_next               = 1'b0;
                    waiting_next            = 1'b0;
                    res.data.outcome        = OUT_TIMEOUT;
                    res.data.attempt_number = attempt_next;
                end
                else
                begin
                    res.data.outcome        = OUT_SEND;
                    res.data.attempt_number = attempt_next + 8'd1;
                end
            end
            res.data.command_sequence = seq_next - 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            waiting_reg      <= 1'b0;
            attempt_reg      <= 8'd0;
            wait_left_reg    <= 16'd0;
            next_delay_reg   <= 16'd0;
            elapsed_reg      <= 20'd0;
            leader_known_reg <= 1'b0;
            leader_index_reg <= 4'd0;
            next_server_reg  <= 4'd0;
            seq_reg          <= 32'd1;
        end
        else
        begin
            busy_reg         <= busy_next;
            waiting_reg      <= waiting_next;
            attempt_reg      <= attempt_next;
            wait_left_reg    <= wait_left_next;
            next_delay_reg   <= next_delay_next;
            elapsed_reg      <= elapsed_next;
            leader_known_reg <= leader_known_next;
            leader_index_reg <= leader_index_next;
            next_server_reg  <= next_server_next;
            seq_reg          <= seq_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lrbc_out_stage.sv =====
// Result register of the retry backoff controller, drives the result channel.
// Depends on lrbc_pkg and lrbc_stream_if.
`default_nettype none

module lrbc_out_stage
    import lrbc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         fire,
    input  wire lrbc_result_t res,
    lrbc_stream_if.source     rsp
);

    logic      valid_reg;
    logic      valid_next;
    lrbc_rsp_t data_reg;

    // fire only happens when this register is empty or being drained
    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
            valid_next = res.valid;
        else if (rsp.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
            data_reg <= res.data;
    end

    assign rsp.valid = valid_reg;
    assign rsp.data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/lrbc_checker.sv =====
// Port-level checks for the retry backoff controller, bound to the top level.
// Depends on lrbc_pkg and leader_retry_backoff_controller_core.
`default_nettype none

module lrbc_checker
    import lrbc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire lrbc_rsp_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("result item changed while stalled");

    a_outcome_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.outcome <= OUT_RETRIES))
        else $error("undefined outcome code");

    // sends and answered attempts always carry a one-based attempt number
    a_attempt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.outcome == OUT_SEND || rsp_data.outcome == OUT_SUCCESS ||
                      rsp_data.outcome == OUT_SERVER_ERROR)
        |-> rsp_data.attempt_number != 8'd0)
        else $error("attempt number zero on a sent or answered attempt");

endmodule

bind leader_retry_backoff_controller_core lrbc_checker u_lrbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire

// ===== tb/lrbc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the retry backoff controller: follows the request, result and
// register write ports, predicts each command's outcome and compares field by field.
// Depends on lrbc_pkg for the item, result and register types.

module lrbc_result_checker
    import lrbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  lrbc_req_t             req_data,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  lrbc_rsp_t             rsp_data,
    output int unsigned           pending,
    output int unsigned           mismatch_total
);

    lrbc_cfg_t   regs;
    bit          busy;
    bit          waiting;
    bit          leader_known;
    logic [7:0]  attempts;
    logic [15:0] wait_left;
    logic [15:0] next_delay;
    logic [19:0] elapsed;
    logic [3:0]  leader_idx;
    logic [3:0]  next_srv;
    logic [31:0] seq_next;

    lrbc_rsp_t expected_outcomes[$];

    function automatic logic [15:0] backoff_ticks(input int unsigned k);
        logic [63:0] d;
        if (regs.initial_delay == 16'd0)
            return 16'd0;
        if (k >= 17)
            return regs.delay_cap;
        d = 64'(regs.initial_delay) << k;
        return (d > 64'(regs.delay_cap)) ? regs.delay_cap : d[15:0];
    endfunction

    function automatic int unsigned server_span();
        int unsigned c;
        c = regs.server_count;
        if (c == 0)
            c = 1;
        if (c > MAX_SERVERS)
            c = MAX_SERVERS;
        if (c > 16)
            c = 16;
        return c;
    endfunction

    // A stale round-robin pointer beyond the server count falls back to 0
    function automatic logic [3:0] route_target();
        if (int'(next_srv) >= server_span())
            next_srv = 4'd0;
        return leader_known ? leader_idx : next_srv;
    endfunction

    function automatic lrbc_rsp_t make_result(input outcome_t o, input logic [3:0] tgt,
                                              input logic [7:0] num);
        lrbc_rsp_t r;
        r.outcome          = o;
        r.target_server    = tgt;
        r.attempt_number   = num;
        r.command_sequence = seq_next - 32'd1;
        return r;
    endfunction

    // Limit and timeout are checked before every send
    function automatic lrbc_rsp_t launch_attempt();
        logic [3:0] tgt;
        if (attempts >= regs.retry_limit) begin
            busy    = 1'b0;
            waiting = 1'b0;
            tgt     = route_target();
            return make_result(OUT_RETRIES, tgt, attempts);
        end
        if (elapsed > regs.cmd_timeout) begin
            busy    = 1'b0;
            waiting = 1'b0;
            tgt     = route_target();
            return make_result(OUT_TIMEOUT, tgt, attempts);
        end
        tgt = route_target();
        return make_result(OUT_SEND, tgt, attempts + 8'd1);
    endfunction

    function automatic void bump_attempts();
        if (attempts < 8'd255)
            attempts = attempts + 8'd1;
    endfunction

    function automatic bit predict_retry(input lrbc_req_t r, output lrbc_rsp_t res);
        logic [3:0] tgt;
        logic [7:0] num;
        res = '0;
        case (r.req_type)
            REQ_START:
            begin
                seq_next     = seq_next + 32'd1;
                busy         = 1'b1;
                waiting      = 1'b0;
                leader_known = 1'b0;
                attempts     = 8'd0;
                elapsed      = 20'd0;
                wait_left    = 16'd0;
                next_delay   = backoff_ticks(0);
                res          = launch_attempt();
                return 1'b1;
            end
            REQ_REPLY:
            begin
                if (!busy || waiting)
                    return 1'b0;
                tgt = route_target();
                num = attempts + 8'd1;
                if (r.rpc_ok) begin
                    if (r.reply_success) begin
                        busy = 1'b0;
                        res  = make_result(OUT_SUCCESS, tgt, num);
                        return 1'b1;
                    end
                    if (r.leader_given) begin
                        leader_known = 1'b1;
                        leader_idx   = r.leader_server;
                        bump_attempts();
                        res = launch_attempt();
                        return 1'b1;
                    end
                    busy = 1'b0;
                    res  = make_result(OUT_SERVER_ERROR, tgt, num);
                    return 1'b1;
                end
                // network failure: back off, and rotate only while no leader is known
                wait_left  = next_delay;
                next_delay = backoff_ticks(int'(attempts) + 1);
                if (!leader_known)
                    next_srv = (int'(next_srv) + 1 >= server_span()) ? 4'd0 : next_srv + 4'd1;
                bump_attempts();
                if (wait_left == 16'd0) begin
                    res = launch_attempt();
                    return 1'b1;
                end
                waiting = 1'b1;
                return 1'b0;
            end
            REQ_TICK:
            begin
                if (!busy)
                    return 1'b0;
                if (elapsed < 20'hFFFFF)
                    elapsed = elapsed + 20'd1;
                if (waiting) begin
                    if (wait_left > 16'd0)
                        wait_left = wait_left - 16'd1;
                    if (wait_left == 16'd0) begin
                        waiting = 1'b0;
                        res     = launch_attempt();
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_total++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lrbc_rsp_t want;
        lrbc_rsp_t predicted;
        if (!rst_n) begin
            regs.initial_delay     = INITIAL_DELAY_RST;
            regs.delay_cap         = DELAY_CAP_RST;
            regs.retry_limit       = RETRY_LIMIT_RST;
            regs.cmd_timeout       = CMD_TIMEOUT_RST;
            regs.server_count      = SERVER_COUNT_RST;
            busy           = 1'b0;
            waiting        = 1'b0;
            leader_known   = 1'b0;
            attempts       = 8'd0;
            wait_left      = 16'd0;
            next_delay     = 16'd0;
            elapsed        = 20'd0;
            leader_idx     = 4'd0;
            next_srv       = 4'd0;
            seq_next       = 32'd1;
            mismatch_total = 0;
            expected_outcomes.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_INITIAL_DELAY:     regs.initial_delay     = cfg_data[15:0];
                    CFG_DELAY_CAP:         regs.delay_cap         = cfg_data[15:0];
                    CFG_RETRY_LIMIT:       regs.retry_limit       = cfg_data[7:0];
                    CFG_CMD_TIMEOUT:       regs.cmd_timeout       = cfg_data[19:0];
                    CFG_SERVER_COUNT:      regs.server_count      = cfg_data[4:0];
                    default: ;
                endcase
            end
            // a result taken at this edge always belongs to an older item
            if (rsp_valid && rsp_ready) begin
                if (expected_outcomes.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected result outcome %0d target %0d attempt %0d seq %0d",
                             $time, rsp_data.outcome, rsp_data.target_server,
                             rsp_data.attempt_number, rsp_data.command_sequence);
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("outcome", 32'(want.outcome), 32'(rsp_data.outcome));
                    check_field("target_server", 32'(want.target_server),
                                32'(rsp_data.target_server));
                    check_field("attempt_number", 32'(want.attempt_number),
                                32'(rsp_data.attempt_number));
                    check_field("command_sequence", want.command_sequence,
                                rsp_data.command_sequence);
                end
            end
            if (req_valid && req_ready) begin
                if (predict_retry(req_data, predicted))
                    expected_outcomes = {expected_outcomes, predicted};
            end
            pending <= expected_outcomes.size();
        end
    end

endmodule

// ===== tb/tb_leader_retry_backoff_controller_core.sv =====
`timescale 1ns / 1ps
// Top of the retry backoff controller testbench: clock, reset, register writes and items,
// with random idling on both channels and one long result hold-off.
// Depends on lrbc_pkg, lrbc_stream_if, the core and lrbc_result_checker.

module tb_leader_retry_backoff_controller_core;
    import lrbc_pkg::*;

    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned CALM_TAIL   = 200;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned STALL_LIMIT = 4000;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned pending;
    int unsigned mismatch_total;
    int unsigned items_sent   = 0;
    int unsigned idle_pct     = 0;
    int unsigned sink_gap     = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;
    bit          squeeze_req  = 1'b0;
    bit          squeeze_done = 1'b0;

    lrbc_stream_if #(.payload_t(lrbc_req_t)) req_if ();
    lrbc_stream_if #(.payload_t(lrbc_rsp_t)) rsp_if ();

    always #1 clk = ~clk;

    leader_retry_backoff_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lrbc_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_if.valid),
        .req_ready      (req_if.ready),
        .req_data       (req_if.data),
        .rsp_valid      (rsp_if.valid),
        .rsp_ready      (rsp_if.ready),
        .rsp_data       (rsp_if.data),
        .pending        (pending),
        .mismatch_total (mismatch_total)
    );

    // Result side: one long hold-off on request, otherwise short random gaps
    always @(posedge clk)
    begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap     <= sink_gap - 1;
            rsp_if.ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2) begin
            sink_gap     <= $urandom_range(0, 8);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_leader_retry_backoff_controller_core: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic lrbc_req_t make_req(input logic [1:0] kind, input logic ok,
                                           input logic succ, input logic lg,
                                           input logic [3:0] srv);
        lrbc_req_t r;
        r.req_type      = kind;
        r.rpc_ok        = ok;
        r.reply_success = succ;
        r.leader_given  = lg;
        r.leader_server = srv;
        return r;
    endfunction

    // valid stays high after acceptance; it is lowered before the random pause here and in settle
    task automatic push_item(input lrbc_req_t r);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic start_cmd();
        push_item(make_req(REQ_START, rbit(), rbit(), rbit(), 4'($urandom)));
    endtask

    task automatic reply(input logic ok, input logic succ, input logic lg,
                         input logic [3:0] srv);
        push_item(make_req(REQ_REPLY, ok, succ, lg, srv));
    endtask

    task automatic tick();
        push_item(make_req(REQ_TICK, rbit(), rbit(), rbit(), 4'($urandom)));
    endtask

    // Waits out every outstanding result, then idles so that items that give none drain too
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input lrbc_cfg_t c);
        write_reg(CFG_INITIAL_DELAY, CFG_DATA_W'(c.initial_delay));
        write_reg(CFG_DELAY_CAP, CFG_DATA_W'(c.delay_cap));
        write_reg(CFG_RETRY_LIMIT, CFG_DATA_W'(c.retry_limit));
        write_reg(CFG_CMD_TIMEOUT, CFG_DATA_W'(c.cmd_timeout));
        write_reg(CFG_SERVER_COUNT, CFG_DATA_W'(c.server_count));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic lrbc_cfg_t random_config();
        lrbc_cfg_t c;
        case ($urandom_range(0, 9))
            0:       c.initial_delay = 16'hFFFF;
            1:       c.initial_delay = 16'd0;
            default: c.initial_delay = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
            0:       c.delay_cap = 16'hFFFF;
            1:       c.delay_cap = 16'($urandom);
            default: c.delay_cap = 16'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 9))
            0:       c.retry_limit = 8'hFF;
            1:       c.retry_limit = 8'd0;
            2:       c.retry_limit = 8'($urandom);
            default: c.retry_limit = 8'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
            0:       c.cmd_timeout = 20'hFFFFF;
            1:       c.cmd_timeout = 20'd0;
            2:       c.cmd_timeout = 20'($urandom);
            default: c.cmd_timeout = 20'($urandom_range(2, 80));
        endcase
        c.server_count = 5'($urandom_range(0, 31));
        return c;
    endfunction

    // One command with a random run of replies, ticks and stray items
    task automatic run_command(input int unsigned span);
        int unsigned pick;
        start_cmd();
        repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                reply(1'b1, 1'b1, rbit(), 4'($urandom));
            end else if (pick < 45) begin
                reply(1'b1, 1'b0, 1'b1, 4'($urandom));
            end else if (pick < 52) begin
                reply(1'b1, 1'b0, 1'b0, 4'($urandom));
            end else if (pick < 85) begin
                reply(1'b0, rbit(), rbit(), 4'($urandom));
                repeat ($urandom_range(0, span)) tick();
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 3)) tick();
            end else begin
                push_item(make_req(REQ_UNUSED, rbit(), rbit(), rbit(), 4'($urandom)));
            end
        end
    endtask

    initial
    begin
        lrbc_cfg_t   c;
        int unsigned phase;
        int unsigned span;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: stray items while idle, each reply kind, drop of a running command
        reply(1'b1, 1'b1, 1'b0, 4'd0);
        tick();
        push_item(make_req(REQ_UNUSED, 1'b1, 1'b1, 1'b1, 4'hF));
        start_cmd();
        reply(1'b1, 1'b1, 1'b0, 4'd0);
        start_cmd();
        reply(1'b1, 1'b0, 1'b1, 4'hF);
        reply(1'b1, 1'b0, 1'b0, 4'd0);
        start_cmd();
        reply(1'b0, 1'b0, 1'b0, 4'd0);
        reply(1'b1, 1'b1, 1'b0, 4'd0);
        tick();
        start_cmd();
        reply(1'b1, 1'b1, 1'b1, 4'hA);

        // zero retry limit, zero backoff, server count of zero
        settle();
        c = '{initial_delay: 16'd0, delay_cap: 16'hFFFF, retry_limit: 8'd0,
              cmd_timeout: 20'd0, server_count: 5'd0};
        program_regs(c);
        start_cmd();
        settle();
        c.retry_limit = 8'd2;
        program_regs(c);
        start_cmd();
        reply(1'b0, 1'b0, 1'b0, 4'd0);
        reply(1'b0, 1'b1, 1'b1, 4'd0);

        // oversized server count, one-tick backoff, timeout reached after a retry
        settle();
        c = '{initial_delay: 16'd1, delay_cap: 16'd1, retry_limit: 8'hFF,
              cmd_timeout: 20'd1, server_count: 5'd31};
        program_regs(c);
        start_cmd();
        reply(1'b0, 1'b0, 1'b0, 4'd0);
        tick();
        tick();
        reply(1'b0, 1'b0, 1'b0, 4'd0);
        tick();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            c = random_config();
            if (phase == 1) begin
                c.retry_limit = 8'hFF;
                c.cmd_timeout = 20'hFFFFF;
            end
            program_regs(c);
            if (items_sent + CALM_TAIL > ITEM_TARGET) begin
                idle_pct <= 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       idle_pct <= 0;
                    1:       idle_pct <= 10;
                    default: idle_pct <= 30;
                endcase
            end
            span = ((c.delay_cap > 16'd40) ? 40 : int'(c.delay_cap)) + 3;
            if (phase == 0) begin
                // starts keep coming while results are held back, so the core backs up
                squeeze_req <= 1'b1;
                repeat (24) start_cmd();
            end
            if (phase == 1) begin
                // redirects only, all the way to the 255-attempt limit
                start_cmd();
                repeat (258) reply(1'b1, 1'b0, 1'b1, 4'($urandom));
            end
            repeat ($urandom_range(6, 20)) begin
                if (items_sent + CALM_TAIL > ITEM_TARGET)
                    idle_pct <= 0;
                if (items_sent < ITEM_TARGET)
                    run_command(span);
            end
            phase++;
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatch_total == 0)
            $display("tb_leader_retry_backoff_controller_core: clean");
        else
            $display("tb_leader_retry_backoff_controller_core: errors");
        $finish;
    end

endmodule
